// File: hdl/dos_pkg.sv
package dos_pkg;

	localparam int WORD_W   = 32;
	localparam int FRAC_W   = 16;
	localparam int OPER_W   = WORD_W + 1;
	localparam int PROD_W   = 2 * OPER_W;
	localparam int MSHIFT_W = PROD_W - FRAC_W;
	localparam int DIV6_SH  = 34;

	localparam int STF_W    = 31;
	localparam int DMP_W    = 31;
	localparam int DT_W     = 17;
	localparam int METHOD_W = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int PC_W     = 6;

	// ceil(2^34 / 6): exact floor(n / 6) for any 32-bit unsigned n
	localparam logic signed [OPER_W-1:0] RECIP6 = 33'sh0_AAAA_AAAB;

	localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	localparam logic [STF_W-1:0]    STF_RST    = 31'd327680;
	localparam logic [DMP_W-1:0]    DMP_RST    = 31'd49152;
	localparam logic [WORD_W-1:0]   FRC_RST    = 32'd655360;
	localparam logic [DT_W-1:0]     DT_RST     = 17'd6554;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STIFFNESS = 3'd0,
		REG_DAMPING   = 3'd1,
		REG_FORCING   = 3'd2,
		REG_TIME_STEP = 3'd3,
		REG_METHOD    = 3'd4
	} cfg_reg_t;

	typedef enum logic [METHOD_W-1:0] {
		METHOD_EULER = 2'd0,
		METHOD_RK2   = 2'd1,
		METHOD_RK4   = 2'd2
	} method_t;

	localparam method_t METHOD_RST = METHOD_RK4;

	// program entry points
	localparam logic [PC_W-1:0] PC_PREFIX = 6'd0;
	localparam logic [PC_W-1:0] PC_EULER  = 6'd4;
	localparam logic [PC_W-1:0] PC_RK2    = 6'd8;
	localparam logic [PC_W-1:0] PC_RK4    = 6'd20;

	typedef enum logic [2:0] {
		OP_MUL  = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_ABS  = 3'd3,
		OP_DIV6 = 3'd4,
		OP_SGN  = 3'd5
	} alu_op_t;

	typedef enum logic [3:0] {
		OPD_X   = 4'd0,
		OPD_V   = 4'd1,
		OPD_XT  = 4'd2,
		OPD_VT  = 4'd3,
		OPD_T   = 4'd4,
		OPD_U   = 4'd5,
		OPD_A   = 4'd6,
		OPD_SX  = 4'd7,
		OPD_SV  = 4'd8,
		OPD_M   = 4'd9,
		OPD_STF = 4'd10,
		OPD_DMP = 4'd11,
		OPD_FRC = 4'd12,
		OPD_DT  = 4'd13,
		OPD_H   = 4'd14
	} opnd_t;

	typedef struct packed {
		alu_op_t op;
		opnd_t   src_a;
		opnd_t   src_b;
		opnd_t   dst;
		logic    branch;
		logic    last;
	} uop_t;

	typedef struct packed {
		logic idle;
		logic run;
		logic fin;
	} seq_stat_t;

	typedef struct packed {
		logic                     func;
		logic signed [WORD_W-1:0] initial_position;
		logic signed [WORD_W-1:0] initial_velocity;
	} item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] position;
		logic signed [WORD_W-1:0] velocity;
		logic                     saturated;
	} result_t;

	function automatic uop_t mk(alu_op_t op, opnd_t a, opnd_t b, opnd_t d,
			logic br, logic lst);
		uop_t u;
		u.op     = op;
		u.src_a  = a;
		u.src_b  = b;
		u.dst    = d;
		u.branch = br;
		u.last   = lst;
		return u;
	endfunction

	// microprogram: common accel prefix, then one tail per method
	function automatic uop_t uop_rom(logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			6'd0:  u = mk(OP_MUL, OPD_STF, OPD_X,  OPD_T,  1'b0, 1'b0);
			6'd1:  u = mk(OP_SUB, OPD_FRC, OPD_T,  OPD_T,  1'b0, 1'b0);
			6'd2:  u = mk(OP_MUL, OPD_DMP, OPD_V,  OPD_U,  1'b0, 1'b0);
			6'd3:  u = mk(OP_SUB, OPD_T,   OPD_U,  OPD_A,  1'b1, 1'b0);
			// Euler
			6'd4:  u = mk(OP_MUL, OPD_DT,  OPD_V,  OPD_T,  1'b0, 1'b0);
			6'd5:  u = mk(OP_ADD, OPD_X,   OPD_T,  OPD_X,  1'b0, 1'b0);
			6'd6:  u = mk(OP_MUL, OPD_DT,  OPD_A,  OPD_T,  1'b0, 1'b0);
			6'd7:  u = mk(OP_ADD, OPD_V,   OPD_T,  OPD_V,  1'b0, 1'b1);
			// midpoint
			6'd8:  u = mk(OP_MUL, OPD_H,   OPD_A,  OPD_T,  1'b0, 1'b0);
			6'd9:  u = mk(OP_ADD, OPD_V,   OPD_T,  OPD_VT, 1'b0, 1'b0);
			6'd10: u = mk(OP_MUL, OPD_H,   OPD_V,  OPD_T,  1'b0, 1'b0);
			6'd11: u = mk(OP_ADD, OPD_X,   OPD_T,  OPD_XT, 1'b0, 1'b0);
			6'd12: u = mk(OP_MUL, OPD_STF, OPD_XT, OPD_T,  1'b0, 1'b0);
			6'd13: u = mk(OP_SUB, OPD_FRC, OPD_T,  OPD_T,  1'b0, 1'b0);
			6'd14: u = mk(OP_MUL, OPD_DMP, OPD_VT, OPD_U,  1'b0, 1'b0);
			6'd15: u = mk(OP_SUB, OPD_T,   OPD_U,  OPD_A,  1'b0, 1'b0);
			6'd16: u = mk(OP_MUL, OPD_DT,  OPD_VT, OPD_T,  1'b0, 1'b0);
			6'd17: u = mk(OP_ADD, OPD_X,   OPD_T,  OPD_X,  1'b0, 1'b0);
			6'd18: u = mk(OP_MUL, OPD_DT,  OPD_A,  OPD_T,  1'b0, 1'b0);
			6'd19: u = mk(OP_ADD, OPD_V,   OPD_T,  OPD_V,  1'b0, 1'b1);
			// RK4: stage 2
			6'd20: u = mk(OP_MUL, OPD_H,   OPD_V,  OPD_T,  1'b0, 1'b0);
			6'd21: u = mk(OP_ADD, OPD_X,   OPD_T,  OPD_XT, 1'b0, 1'b0);
			6'd22: u = mk(OP_MUL, OPD_H,   OPD_A,  OPD_T,  1'b0, 1'b0);
			6'd23: u = mk(OP_ADD, OPD_V,   OPD_T,  OPD_VT, 1'b0, 1'b0);
			6'd24: u = mk(OP_ADD, OPD_VT,  OPD_VT, OPD_T,  1'b0, 1'b0);
			6'd25: u = mk(OP_ADD, OPD_V,   OPD_T,  OPD_SX, 1'b0, 1'b0);
			6'd26: u = mk(OP_MUL, OPD_STF, OPD_XT, OPD_T,  1'b0, 1'b0);
			6'd27: u = mk(OP_SUB, OPD_FRC, OPD_T,  OPD_T,  1'b0, 1'b0);
			6'd28: u = mk(OP_MUL, OPD_DMP, OPD_VT, OPD_U,  1'b0, 1'b0);
			6'd29: u = mk(OP_SUB, OPD_T,   OPD_U,  OPD_U,  1'b0, 1'b0);
			6'd30: u = mk(OP_ADD, OPD_U,   OPD_U,  OPD_T,  1'b0, 1'b0);
			6'd31: u = mk(OP_ADD, OPD_A,   OPD_T,  OPD_SV, 1'b0, 1'b0);
			// RK4: stage 3
			6'd32: u = mk(OP_MUL, OPD_H,   OPD_VT, OPD_T,  1'b0, 1'b0);
			6'd33: u = mk(OP_ADD, OPD_X,   OPD_T,  OPD_XT, 1'b0, 1'b0);
			6'd34: u = mk(OP_MUL, OPD_H,   OPD_U,  OPD_T,  1'b0, 1'b0);
			6'd35: u = mk(OP_ADD, OPD_V,   OPD_T,  OPD_VT, 1'b0, 1'b0);
			6'd36: u = mk(OP_ADD, OPD_VT,  OPD_VT, OPD_T,  1'b0, 1'b0);
			6'd37: u = mk(OP_ADD, OPD_SX,  OPD_T,  OPD_SX, 1'b0, 1'b0);
			6'd38: u = mk(OP_MUL, OPD_STF, OPD_XT, OPD_T,  1'b0, 1'b0);
			6'd39: u = mk(OP_SUB, OPD_FRC, OPD_T,  OPD_T,  1'b0, 1'b0);
			6'd40: u = mk(OP_MUL, OPD_DMP, OPD_VT, OPD_U,  1'b0, 1'b0);
			6'd41: u = mk(OP_SUB, OPD_T,   OPD_U,  OPD_A,  1'b0, 1'b0);
			6'd42: u = mk(OP_ADD, OPD_A,   OPD_A,  OPD_T,  1'b0, 1'b0);
			6'd43: u = mk(OP_ADD, OPD_SV,  OPD_T,  OPD_SV, 1'b0, 1'b0);
			// RK4: stage 4
			6'd44: u = mk(OP_MUL, OPD_DT,  OPD_VT, OPD_T,  1'b0, 1'b0);
			6'd45: u = mk(OP_ADD, OPD_X,   OPD_T,  OPD_XT, 1'b0, 1'b0);
			6'd46: u = mk(OP_MUL, OPD_DT,  OPD_A,  OPD_T,  1'b0, 1'b0);
			6'd47: u = mk(OP_ADD, OPD_V,   OPD_T,  OPD_VT, 1'b0, 1'b0);
			6'd48: u = mk(OP_ADD, OPD_SX,  OPD_VT, OPD_SX, 1'b0, 1'b0);
			6'd49: u = mk(OP_MUL, OPD_STF, OPD_XT, OPD_T,  1'b0, 1'b0);
			6'd50: u = mk(OP_SUB, OPD_FRC, OPD_T,  OPD_T,  1'b0, 1'b0);
			6'd51: u = mk(OP_MUL, OPD_DMP, OPD_VT, OPD_U,  1'b0, 1'b0);
			6'd52: u = mk(OP_SUB, OPD_T,   OPD_U,  OPD_A,  1'b0, 1'b0);
			6'd53: u = mk(OP_ADD, OPD_SV,  OPD_A,  OPD_SV, 1'b0, 1'b0);
			// RK4: weighted update, divide by six toward zero
			6'd54: u = mk(OP_MUL, OPD_DT,  OPD_SX, OPD_M,  1'b0, 1'b0);
			6'd55: u = mk(OP_ABS, OPD_M,   OPD_M,  OPD_T,  1'b0, 1'b0);
			6'd56: u = mk(OP_DIV6, OPD_T,  OPD_T,  OPD_T,  1'b0, 1'b0);
			6'd57: u = mk(OP_SGN, OPD_M,   OPD_T,  OPD_T,  1'b0, 1'b0);
			6'd58: u = mk(OP_ADD, OPD_X,   OPD_T,  OPD_X,  1'b0, 1'b0);
			6'd59: u = mk(OP_MUL, OPD_DT,  OPD_SV, OPD_M,  1'b0, 1'b0);
			6'd60: u = mk(OP_ABS, OPD_M,   OPD_M,  OPD_T,  1'b0, 1'b0);
			6'd61: u = mk(OP_DIV6, OPD_T,  OPD_T,  OPD_T,  1'b0, 1'b0);
			6'd62: u = mk(OP_SGN, OPD_M,   OPD_T,  OPD_T,  1'b0, 1'b0);
			6'd63: u = mk(OP_ADD, OPD_V,   OPD_T,  OPD_V,  1'b0, 1'b1);
			default: u = mk(OP_ADD, OPD_X, OPD_X,  OPD_T,  1'b0, 1'b1);
		endcase
		return u;
	endfunction

endpackage

// File: hdl/damped_oscillator_ode_stepper.sv
// Forced damped oscillator stepper, x'' = forcing - stiffness*x - damping*v, in signed
// Q16.16. A step transaction (func 0) advances the held position and velocity by one
// time_step with forward Euler, midpoint RK2 or classic RK4 (method 3 runs RK4); a load
// transaction (func 1) sets them directly. Each transaction returns one result with the
// new state and a flag that is set when any intermediate value clamped to the 32-bit
// range. All arithmetic runs through one saturating multiply/add unit driven by a
// microcode sequencer, one operation per cycle: a step runs the shared acceleration
// prefix and then the tail for its method, hands the result to the output register
// and returns to idle, where the next transaction is accepted; a load goes straight
// to the hand-off. The hand-off waits while the output register holds a result not
// yet taken. The input is not ready while a transaction is in progress, but a
// finished result may sit in the output register while the next is accepted.
// Configuration is taken through cfg_we/cfg_index/cfg_data and must only be written
// while the block is idle.
module damped_oscillator_ode_stepper (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dos_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dos_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  dos_pkg::item_t                  item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output dos_pkg::result_t                result
);

	// configuration
	logic [dos_pkg::STF_W-1:0]    stiffness_q;
	logic [dos_pkg::DMP_W-1:0]    damping_q;
	logic [dos_pkg::WORD_W-1:0]   forcing_q;
	logic [dos_pkg::DT_W-1:0]     time_step_q;
	logic [dos_pkg::METHOD_W-1:0] method_q;

	// state and scratch registers
	logic signed [dos_pkg::WORD_W-1:0] x_q, v_q;
	logic signed [dos_pkg::WORD_W-1:0] xt_q, vt_q, t_q, u_q, a_q, sx_q, sv_q, m_q;
	logic                              flag_q;

	logic                              result_valid_q;
	dos_pkg::result_t                  result_q;

	dos_pkg::uop_t                     uop;
	dos_pkg::seq_stat_t                stat;
	logic signed [dos_pkg::WORD_W-1:0] opa, opb, alu_res;
	logic                              alu_sat;
	logic                              accept;
	logic                              slot_free;

	assign accept     = item_valid && item_ready;
	assign item_ready = stat.idle;
	assign slot_free  = !result_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiffness_q <= dos_pkg::STF_RST;
			damping_q   <= dos_pkg::DMP_RST;
			forcing_q   <= dos_pkg::FRC_RST;
			time_step_q <= dos_pkg::DT_RST;
			method_q    <= dos_pkg::METHOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dos_pkg::REG_STIFFNESS: stiffness_q <= cfg_data[dos_pkg::STF_W-1:0];
				dos_pkg::REG_DAMPING:   damping_q   <= cfg_data[dos_pkg::DMP_W-1:0];
				dos_pkg::REG_FORCING:   forcing_q   <= cfg_data[dos_pkg::WORD_W-1:0];
				dos_pkg::REG_TIME_STEP: time_step_q <= cfg_data[dos_pkg::DT_W-1:0];
				dos_pkg::REG_METHOD:    method_q    <= cfg_data[dos_pkg::METHOD_W-1:0];
				default: ;  // unmapped index: dropped
			endcase
		end
	end

	dos_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.load      (item.func),
		.method    (method_q),
		.slot_free (slot_free),
		.uop       (uop),
		.stat      (stat)
	);

	// operand A select
	always_comb begin
		case (uop.src_a)
			dos_pkg::OPD_X:   opa = x_q;
			dos_pkg::OPD_V:   opa = v_q;
			dos_pkg::OPD_XT:  opa = xt_q;
			dos_pkg::OPD_VT:  opa = vt_q;
			dos_pkg::OPD_T:   opa = t_q;
			dos_pkg::OPD_U:   opa = u_q;
			dos_pkg::OPD_A:   opa = a_q;
			dos_pkg::OPD_SX:  opa = sx_q;
			dos_pkg::OPD_SV:  opa = sv_q;
			dos_pkg::OPD_M:   opa = m_q;
			dos_pkg::OPD_STF: opa = {1'b0, stiffness_q};
			dos_pkg::OPD_DMP: opa = {1'b0, damping_q};
			dos_pkg::OPD_FRC: opa = forcing_q;
			dos_pkg::OPD_DT:  opa = {{(dos_pkg::WORD_W-dos_pkg::DT_W){1'b0}}, time_step_q};
			dos_pkg::OPD_H:   opa = {{(dos_pkg::WORD_W-dos_pkg::DT_W+1){1'b0}},
				time_step_q[dos_pkg::DT_W-1:1]};
			default:          opa = x_q;
		endcase
	end

	// operand B select; coefficients never appear here
	always_comb begin
		case (uop.src_b)
			dos_pkg::OPD_X:   opb = x_q;
			dos_pkg::OPD_V:   opb = v_q;
			dos_pkg::OPD_XT:  opb = xt_q;
			dos_pkg::OPD_VT:  opb = vt_q;
			dos_pkg::OPD_T:   opb = t_q;
			dos_pkg::OPD_U:   opb = u_q;
			dos_pkg::OPD_A:   opb = a_q;
			dos_pkg::OPD_SX:  opb = sx_q;
			dos_pkg::OPD_SV:  opb = sv_q;
			dos_pkg::OPD_M:   opb = m_q;
			default:          opb = t_q;
		endcase
	end

	dos_alu u_alu (
		.op  (uop.op),
		.a   (opa),
		.b   (opb),
		.res (alu_res),
		.sat (alu_sat)
	);

	// position/velocity are architectural state and reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			v_q <= '0;
		end else if (accept && item.func) begin
			x_q <= item.initial_position;
			v_q <= item.initial_velocity;
		end else if (stat.run) begin
			if (uop.dst == dos_pkg::OPD_X)
				x_q <= alu_res;
			if (uop.dst == dos_pkg::OPD_V)
				v_q <= alu_res;
		end
	end

	// scratch writeback
	always_ff @(posedge clk) begin
		if (stat.run) begin
			case (uop.dst)
				dos_pkg::OPD_XT: xt_q <= alu_res;
				dos_pkg::OPD_VT: vt_q <= alu_res;
				dos_pkg::OPD_T:  t_q  <= alu_res;
				dos_pkg::OPD_U:  u_q  <= alu_res;
				dos_pkg::OPD_A:  a_q  <= alu_res;
				dos_pkg::OPD_SX: sx_q <= alu_res;
				dos_pkg::OPD_SV: sv_q <= alu_res;
				dos_pkg::OPD_M:  m_q  <= alu_res;
				default: ;  // state registers handled above
			endcase
		end
	end

	// sticky clamp flag for the transaction in progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			flag_q <= 1'b0;
		else if (accept)
			flag_q <= 1'b0;
		else if (stat.run && alu_sat)
			flag_q <= 1'b1;
	end

	// output register decouples the result side from the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (stat.fin && slot_free)
			result_valid_q <= 1'b1;
		else if (result_ready)
			result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (stat.fin && slot_free) begin
			result_q.position  <= x_q;
			result_q.velocity  <= v_q;
			result_q.saturated <= flag_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !item_ready)
		else $error("input ready right after a transaction was accepted");

	a_load_clears_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.func) |=> !flag_q)
		else $error("clamp flag set after a load");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(stat.fin))
		else $error("result presented without a finished transaction");

	a_fin_publishes: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.fin && slot_free) |=> (result_valid_q && stat.idle))
		else $error("finished transaction not published");

endmodule

// File: hdl/dos_alu.sv
// Shared arithmetic unit: Q-format multiply, add, subtract, all saturating;
// plus the helper ops for the divide by six.
module dos_alu (
	input  dos_pkg::alu_op_t                   op,
	input  logic signed [dos_pkg::WORD_W-1:0]  a,
	input  logic signed [dos_pkg::WORD_W-1:0]  b,
	output logic signed [dos_pkg::WORD_W-1:0]  res,
	output logic                               sat
);

	logic signed [dos_pkg::OPER_W-1:0]   mul_a;
	logic signed [dos_pkg::OPER_W-1:0]   mul_b;
	logic signed [dos_pkg::PROD_W-1:0]   prod;
	logic        [dos_pkg::MSHIFT_W-1:0] prod_sh;
	logic                                mul_ovf;
	logic signed [dos_pkg::OPER_W-1:0]   a_ext;
	logic signed [dos_pkg::OPER_W-1:0]   b_ext;
	logic signed [dos_pkg::OPER_W-1:0]   sum;
	logic signed [dos_pkg::OPER_W-1:0]   diff;

	always_comb begin
		if (op == dos_pkg::OP_DIV6) begin
			mul_a = {1'b0, a};
			mul_b = dos_pkg::RECIP6;
		end else begin
			mul_a = {a[dos_pkg::WORD_W-1], a};
			mul_b = {b[dos_pkg::WORD_W-1], b};
		end
	end

	assign prod    = mul_a * mul_b;
	// arithmetic shift by the fraction width: floor rounding
	assign prod_sh = prod[dos_pkg::PROD_W-1:dos_pkg::FRAC_W];
	assign mul_ovf = !((&prod_sh[dos_pkg::MSHIFT_W-1:dos_pkg::WORD_W-1])
		|| !(|prod_sh[dos_pkg::MSHIFT_W-1:dos_pkg::WORD_W-1]));

	assign a_ext = {a[dos_pkg::WORD_W-1], a};
	assign b_ext = {b[dos_pkg::WORD_W-1], b};
	assign sum   = a_ext + b_ext;
	assign diff  = a_ext - b_ext;

	always_comb begin
		res = sum[dos_pkg::WORD_W-1:0];
		sat = 1'b0;
		case (op)
			dos_pkg::OP_MUL: begin
				sat = mul_ovf;
				if (mul_ovf)
					res = prod_sh[dos_pkg::MSHIFT_W-1] ? dos_pkg::WORD_MIN : dos_pkg::WORD_MAX;
				else
					res = prod_sh[dos_pkg::WORD_W-1:0];
			end
			dos_pkg::OP_ADD: begin
				sat = sum[dos_pkg::WORD_W] != sum[dos_pkg::WORD_W-1];
				if (sat)
					res = sum[dos_pkg::WORD_W] ? dos_pkg::WORD_MIN : dos_pkg::WORD_MAX;
				else
					res = sum[dos_pkg::WORD_W-1:0];
			end
			dos_pkg::OP_SUB: begin
				sat = diff[dos_pkg::WORD_W] != diff[dos_pkg::WORD_W-1];
				if (sat)
					res = diff[dos_pkg::WORD_W] ? dos_pkg::WORD_MIN : dos_pkg::WORD_MAX;
				else
					res = diff[dos_pkg::WORD_W-1:0];
			end
			// magnitude as unsigned; the most negative value maps to its own pattern
			dos_pkg::OP_ABS:  res = a[dos_pkg::WORD_W-1] ? -a : a;
			dos_pkg::OP_DIV6: res = prod[dos_pkg::DIV6_SH +: dos_pkg::WORD_W];
			// restore the sign of a onto the small quotient in b
			dos_pkg::OP_SGN:  res = a[dos_pkg::WORD_W-1] ? -b : b;
			default: begin
				res = sum[dos_pkg::WORD_W-1:0];
				sat = 1'b0;
			end
		endcase
	end

endmodule

// File: hdl/dos_seq.sv
// Microcode sequencer: program counter, method dispatch, and run state.
module dos_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          load,
	input  logic [dos_pkg::METHOD_W-1:0]  method,
	input  logic                          slot_free,
	output dos_pkg::uop_t                 uop,
	output dos_pkg::seq_stat_t            stat
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t                  state_q;
	logic [dos_pkg::PC_W-1:0] pc_q;
	logic [dos_pkg::PC_W-1:0] tail_pc;

	assign uop = dos_pkg::uop_rom(pc_q);

	always_comb begin
		case (method)
			dos_pkg::METHOD_EULER: tail_pc = dos_pkg::PC_EULER;
			dos_pkg::METHOD_RK2:   tail_pc = dos_pkg::PC_RK2;
			default:               tail_pc = dos_pkg::PC_RK4;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= dos_pkg::PC_PREFIX;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						pc_q    <= dos_pkg::PC_PREFIX;
						state_q <= load ? S_FIN : S_RUN;
					end
				end
				S_RUN: begin
					if (uop.last)
						state_q <= S_FIN;
					else if (uop.branch)
						pc_q <= tail_pc;
					else
						pc_q <= pc_q + 1'b1;
				end
				S_FIN: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign stat.idle = state_q == S_IDLE;
	assign stat.run  = state_q == S_RUN;
	assign stat.fin  = state_q == S_FIN;

endmodule

// File: tb/sv/damped_oscillator_ode_stepper_tb.sv
module damped_oscillator_ode_stepper_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES       = 10;
	localparam int STALL_LIMIT        = 4000;  // cycles with no transaction on either side
	localparam int HOLD_OFF_CYCLES    = 400;
	localparam int SETTLE_CYCLES      = 80;    // a bit more than one RK4 step plus output
	localparam int REPORT_MAX         = 10;
	localparam int SETTINGS_PER_PHASE = 5;
	localparam int ITEMS_PER_SETTING  = 77;
	localparam int LOAD_PCT           = 10;

	localparam int Q_ONE = 65536;  // 1.0 in Q16.16

	// func field codes
	localparam logic FUNC_STEP = 1'b0;
	localparam logic FUNC_LOAD = 1'b1;

	// method 3 has no package name; the block runs it as RK4
	localparam logic [dos_pkg::METHOD_W-1:0] METHOD_SPARE = 2'd3;

	localparam longint WORD_HI = (longint'(1) <<< (dos_pkg::WORD_W - 1)) - 1;
	localparam longint WORD_LO = -WORD_HI - 1;

	// ------------------------------------------------------------------
	// DUT signals. Every input starts at a known value at time zero.
	// ------------------------------------------------------------------
	logic                           clk;
	logic                           arst_n       = 1'b0;
	logic                           cfg_we       = 1'b0;
	logic [dos_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [dos_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
	logic                           item_valid   = 1'b0;
	logic                           item_ready;
	dos_pkg::item_t                 item         = '0;
	logic                           result_valid;
	logic                           result_ready = 1'b0;
	dos_pkg::result_t               result;

	// ------------------------------------------------------------------
	// Oscillator shadow: coefficients and state as the block holds them
	// ------------------------------------------------------------------
	longint                       stf_coef   = longint'(dos_pkg::STF_RST);
	longint                       dmp_coef   = longint'(dos_pkg::DMP_RST);
	longint                       frc_term   = longint'($signed(dos_pkg::FRC_RST));
	longint                       dt_step    = longint'(dos_pkg::DT_RST);
	logic [dos_pkg::METHOD_W-1:0] method_sel = dos_pkg::METHOD_RST;
	longint                       pos_now    = 0;
	longint                       vel_now    = 0;
	bit                           clamped;  // any clamp during the current transaction

	dos_pkg::result_t expected_states[$];  // predicted results, oldest first

	// traffic shaping knobs
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	logic hold_off       = 1'b0;  // receiver holds result_ready low while set

	int fail_count   = 0;
	int stall_cycles = 0;

	damped_oscillator_ode_stepper i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Fixed-point arithmetic of the stepper. Every op saturates to the
	// 32-bit signed range and any clamp raises the transaction's flag.
	// ------------------------------------------------------------------
	function automatic longint sat_word(longint v);
		if (v > WORD_HI) begin
			clamped = 1'b1;
			return WORD_HI;
		end
		if (v < WORD_LO) begin
			clamped = 1'b1;
			return WORD_LO;
		end
		return v;
	endfunction

	// operands never exceed 2^31 in magnitude, so the product fits in 64 bits;
	// arithmetic shift gives the floor
	function automatic longint fx_mul(longint a, longint b);
		return sat_word((a * b) >>> dos_pkg::FRAC_W);
	endfunction

	function automatic longint fx_add(longint a, longint b);
		return sat_word(a + b);
	endfunction

	function automatic longint fx_sub(longint a, longint b);
		return sat_word(a - b);
	endfunction

	// v' = (forcing - k*x) - c*v, saturating after each op
	function automatic longint spring_accel(longint x, longint v);
		return fx_sub(fx_sub(frc_term, fx_mul(stf_coef, x)), fx_mul(dmp_coef, v));
	endfunction

	function automatic void advance_state();
		longint x, v, h, k1v, xm, k2x, k2v, k3x, k3v, k4x, k4v, sx, sv;
		x   = pos_now;
		v   = vel_now;
		h   = dt_step >>> 1;
		k1v = spring_accel(x, v);
		case (method_sel)
			dos_pkg::METHOD_EULER: begin
				pos_now = fx_add(x, fx_mul(dt_step, v));
				vel_now = fx_add(v, fx_mul(dt_step, k1v));
			end
			dos_pkg::METHOD_RK2: begin
				k2x     = fx_add(v, fx_mul(h, k1v));
				xm      = fx_add(x, fx_mul(h, v));
				k2v     = spring_accel(xm, k2x);
				pos_now = fx_add(x, fx_mul(dt_step, k2x));
				vel_now = fx_add(v, fx_mul(dt_step, k2v));
			end
			default: begin
				// RK4, also taken for the spare method code
				xm  = fx_add(x, fx_mul(h, v));
				k2x = fx_add(v, fx_mul(h, k1v));
				k2v = spring_accel(xm, k2x);
				xm  = fx_add(x, fx_mul(h, k2x));
				k3x = fx_add(v, fx_mul(h, k2v));
				k3v = spring_accel(xm, k3x);
				xm  = fx_add(x, fx_mul(dt_step, k3x));
				k4x = fx_add(v, fx_mul(dt_step, k3v));
				k4v = spring_accel(xm, k4x);
				sx  = fx_add(fx_add(fx_add(v, fx_add(k2x, k2x)), fx_add(k3x, k3x)), k4x);
				sv  = fx_add(fx_add(fx_add(k1v, fx_add(k2v, k2v)), fx_add(k3v, k3v)), k4v);
				// longint division truncates toward zero, as the block does
				pos_now = fx_add(x, fx_mul(dt_step, sx) / 6);
				vel_now = fx_add(v, fx_mul(dt_step, sv) / 6);
			end
		endcase
	endfunction

	// Next state and result for one accepted transaction.
	function automatic dos_pkg::result_t predict_state(dos_pkg::item_t it);
		dos_pkg::result_t r;
		clamped = 1'b0;
		if (it.func == FUNC_LOAD) begin
			pos_now = sat_word(longint'($signed(it.initial_position)));
			vel_now = sat_word(longint'($signed(it.initial_velocity)));
			clamped = 1'b0;  // a load never reports saturation
		end else begin
			advance_state();
		end
		r.position  = pos_now[dos_pkg::WORD_W-1:0];
		r.velocity  = vel_now[dos_pkg::WORD_W-1:0];
		r.saturated = clamped;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Value pickers: full-range noise, values around the working range
	// of a sane oscillator, and the saturation corners.
	// ------------------------------------------------------------------
	function automatic logic [dos_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom();
			8:          return $urandom_range(1) ? dos_pkg::WORD_MAX : dos_pkg::WORD_MIN;
			9:          return $urandom_range(1) ? '0 : ($urandom_range(1) ? 32'd1 : '1);
			default:    return $urandom_range(32 * Q_ONE) - 16 * Q_ONE;
		endcase
	endfunction

	// stiffness/damping: only 31 bits are kept, upper bit is noise
	function automatic logic [dos_pkg::CFG_DATA_W-1:0] pick_coef();
		case ($urandom_range(9))
			6, 7:    return $urandom();
			8:       return '0;
			9:       return $urandom_range(1) ? 32'h7FFF_FFFF : '1;
			default: return $urandom_range(20 * Q_ONE);
		endcase
	endfunction

	// time step: mostly small, with zero, 1.0, the 17-bit top and noise
	function automatic logic [dos_pkg::CFG_DATA_W-1:0] pick_dt();
		case ($urandom_range(9))
			0:       return '0;
			1:       return $urandom();
			2:       return Q_ONE;
			3:       return {{(dos_pkg::CFG_DATA_W - dos_pkg::DT_W){1'b0}},
				{dos_pkg::DT_W{1'b1}}};
			default: return $urandom_range(Q_ONE / 5, 1);
		endcase
	endfunction

	function automatic dos_pkg::item_t make_item(logic func,
			logic [dos_pkg::WORD_W-1:0] p, logic [dos_pkg::WORD_W-1:0] v);
		dos_pkg::item_t it;
		it.func             = func;
		it.initial_position = p;
		it.initial_velocity = v;
		return it;
	endfunction

	function automatic void report_fail(string what, longint want, longint got);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("%0t: %s: expected %h, actual %h", $realtime, what, want, got);
	endfunction

	// ------------------------------------------------------------------
	// Sender. valid is left high after a transaction: the next call either
	// presents a new item in the same step or drops valid for an idle gap,
	// so valid is never lowered and raised in one step. Anything else that
	// follows a send must drop valid first (drain does).
	// ------------------------------------------------------------------
	task automatic send_item(dos_pkg::item_t it);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (!item_ready);
		expected_states.push_back(predict_state(it));
	endtask

	// Wait for every predicted result, then a few cycles of quiet.
	task automatic drain();
		item_valid <= 1'b0;
		while (expected_states.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register write; the caller lowers cfg_we after a batch.
	task automatic write_reg(logic [dos_pkg::CFG_IDX_W-1:0] idx,
			logic [dos_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			dos_pkg::REG_STIFFNESS: stf_coef   = longint'(data[dos_pkg::STF_W-1:0]);
			dos_pkg::REG_DAMPING:   dmp_coef   = longint'(data[dos_pkg::DMP_W-1:0]);
			dos_pkg::REG_FORCING:   frc_term   = longint'($signed(data));
			dos_pkg::REG_TIME_STEP: dt_step    = longint'(data[dos_pkg::DT_W-1:0]);
			dos_pkg::REG_METHOD:    method_sel = data[dos_pkg::METHOD_W-1:0];
			default: ;  // unmapped index, dropped by the block
		endcase
	endtask

	// Full register set, then noise to the unmapped indexes, which must
	// leave everything untouched. Only called with the block idle.
	task automatic apply_setting(logic [dos_pkg::CFG_DATA_W-1:0] stf,
			logic [dos_pkg::CFG_DATA_W-1:0] dmp, logic [dos_pkg::CFG_DATA_W-1:0] frc,
			logic [dos_pkg::CFG_DATA_W-1:0] dt, logic [dos_pkg::CFG_DATA_W-1:0] meth);
		write_reg(dos_pkg::REG_STIFFNESS, stf);
		write_reg(dos_pkg::REG_DAMPING, dmp);
		write_reg(dos_pkg::REG_FORCING, frc);
		write_reg(dos_pkg::REG_TIME_STEP, dt);
		write_reg(dos_pkg::REG_METHOD, meth);
		for (int i = int'(dos_pkg::REG_METHOD) + 1; i < (1 << dos_pkg::CFG_IDX_W); i++)
			write_reg(i[dos_pkg::CFG_IDX_W-1:0], $urandom());
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset coefficients (RK4, k 5.0, c 0.75, F 10.0, dt ~0.1): a step out of
	// the zero state, then loads at opposite corners followed by a step that
	// must saturate.
	task automatic test_reset_defaults();
		send_item(make_item(FUNC_STEP, $urandom(), $urandom()));
		send_item(make_item(FUNC_LOAD, dos_pkg::WORD_MAX, dos_pkg::WORD_MIN));
		send_item(make_item(FUNC_STEP, $urandom(), $urandom()));
		send_item(make_item(FUNC_LOAD, dos_pkg::WORD_MIN, dos_pkg::WORD_MAX));
		send_item(make_item(FUNC_STEP, $urandom(), $urandom()));
		drain();
	endtask

	// Every method code. Euler runs with the coefficient extremes, the spare
	// code (treated as RK4) with no spring, no damping and full forcing.
	task automatic test_methods();
		logic [dos_pkg::METHOD_W-1:0] codes[4];
		codes = '{dos_pkg::METHOD_EULER, dos_pkg::METHOD_RK2, dos_pkg::METHOD_RK4,
			METHOD_SPARE};
		for (int m = 0; m < 4; m++) begin
			if (codes[m] == dos_pkg::METHOD_EULER)
				apply_setting(32'h7FFF_FFFF, 32'h7FFF_FFFF, dos_pkg::WORD_MIN, Q_ONE,
					dos_pkg::CFG_DATA_W'(codes[m]));
			else if (codes[m] == METHOD_SPARE)
				apply_setting('0, '0, dos_pkg::WORD_MAX, Q_ONE,
					dos_pkg::CFG_DATA_W'(codes[m]));
			else
				apply_setting(dos_pkg::CFG_DATA_W'(dos_pkg::STF_RST),
					dos_pkg::CFG_DATA_W'(dos_pkg::DMP_RST), dos_pkg::FRC_RST,
					dos_pkg::CFG_DATA_W'(dos_pkg::DT_RST),
					dos_pkg::CFG_DATA_W'(codes[m]));
			send_item(make_item(FUNC_LOAD, Q_ONE, -2 * Q_ONE));
			send_item(make_item(FUNC_STEP, $urandom(), $urandom()));
			send_item(make_item(FUNC_STEP, $urandom(), $urandom()));
			drain();
		end
	endtask

	// Zero step must hold the state; then the largest 17-bit step (just under
	// 2.0), written with all upper data bits set.
	task automatic test_step_sizes();
		apply_setting(dos_pkg::CFG_DATA_W'(dos_pkg::STF_RST),
			dos_pkg::CFG_DATA_W'(dos_pkg::DMP_RST), dos_pkg::FRC_RST, '0,
			dos_pkg::CFG_DATA_W'(dos_pkg::METHOD_RK4));
		send_item(make_item(FUNC_LOAD, 3 * Q_ONE, Q_ONE));
		send_item(make_item(FUNC_STEP, $urandom(), $urandom()));
		drain();
		apply_setting(dos_pkg::CFG_DATA_W'(dos_pkg::STF_RST),
			dos_pkg::CFG_DATA_W'(dos_pkg::DMP_RST), dos_pkg::FRC_RST, '1,
			dos_pkg::CFG_DATA_W'(dos_pkg::METHOD_RK4));
		send_item(make_item(FUNC_STEP, $urandom(), $urandom()));
		drain();
	endtask

	// Receiver goes dark for a long stretch while the sender keeps offering,
	// so a result parks in the output register and the input stalls.
	task automatic test_backpressure();
		apply_setting(dos_pkg::CFG_DATA_W'(dos_pkg::STF_RST),
			dos_pkg::CFG_DATA_W'(dos_pkg::DMP_RST), dos_pkg::FRC_RST,
			dos_pkg::CFG_DATA_W'(dos_pkg::DT_RST),
			dos_pkg::CFG_DATA_W'(dos_pkg::METHOD_EULER));
		fork
			begin
				hold_off <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off <= 1'b0;
			end
			begin
				send_item(make_item(FUNC_LOAD, 2 * Q_ONE, '0));
				for (int n = 0; n < 23; n++)
					send_item(make_item(FUNC_STEP, $urandom(), $urandom()));
			end
		join
		drain();
	endtask

	// Random coefficients and traffic under four idle profiles. Each setting
	// opens with a load of sane values so the trajectory starts in range;
	// later loads inject anything, corners included.
	task automatic test_random_phases();
		int send_pcts[4];
		int recv_pcts[4];
		send_pcts = '{0, 55, 0, 30};
		recv_pcts = '{0, 0, 55, 30};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = send_pcts[ph];
			recv_stall_pct = recv_pcts[ph];
			for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
				drain();
				apply_setting(pick_coef(), pick_coef(), pick_word(), pick_dt(), $urandom());
				send_item(make_item(FUNC_LOAD,
					$urandom_range(8 * Q_ONE) - 4 * Q_ONE,
					$urandom_range(8 * Q_ONE) - 4 * Q_ONE));
				for (int n = 1; n < ITEMS_PER_SETTING; n++)
					send_item(make_item($urandom_range(99) < LOAD_PCT ? FUNC_LOAD : FUNC_STEP,
						pick_word(), pick_word()));
			end
		end
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	// ------------------------------------------------------------------
	// Result checker and receiver stall generator. Each accepted result
	// is matched against the oldest prediction, field by field.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		dos_pkg::result_t want;
		if (result_valid && result_ready) begin
			if (expected_states.size() == 0) begin
				report_fail("result with no transaction pending", 0,
					longint'({result.position, result.velocity}));
			end else begin
				want = expected_states.pop_front();
				if (result.position !== want.position)
					report_fail("position", longint'(want.position),
						longint'(result.position));
				if (result.velocity !== want.velocity)
					report_fail("velocity", longint'(want.velocity),
						longint'(result.velocity));
				if (result.saturated !== want.saturated)
					report_fail("saturated", longint'(want.saturated),
						longint'(result.saturated));
			end
		end
		result_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: any transaction on either side restarts the count.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Sequence: single reset, directed checks, backpressure, random soak.
	// ------------------------------------------------------------------
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_methods();
		test_step_sizes();
		test_backpressure();
		test_random_phases();

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_states.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/dos_pkg.sv
hdl/dos_alu.sv
hdl/dos_seq.sv
hdl/damped_oscillator_ode_stepper.sv
tb/sv/damped_oscillator_ode_stepper_tb.sv
